>>> src/twn_pkg.sv
package twn_pkg;

	// Byte codes used by the classifier and the front part.
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_NL  = 8'h0A;
	localparam logic [7:0] CHAR_VT  = 8'h0B;
	localparam logic [7:0] CHAR_FF  = 8'h0C;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_SP  = 8'h20;

	// Hard ceiling on the per-string output length.
	localparam int unsigned LENGTH_LIMIT = 1023;
	localparam int unsigned CNT_W = 10;
	localparam int unsigned LIM_W = 16;
	localparam logic [CNT_W-1:0] LEN_CAP_RESET = 10'd320;

	// Command queue between the front and the back.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       has_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       end_of_string;
	} result_t;

	// One queued command: one or two output bytes, or a bare end marker.
	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic       bare;
		logic       two;
		logic       eos;
	} cmd_t;

	typedef enum logic [1:0] {
		BC_BREAK,
		BC_BLANK,
		BC_VISIBLE
	} byte_class_t;

	function automatic byte_class_t classify(input logic [7:0] b);
		byte_class_t c;
		unique case (b) inside
			CHAR_NL, CHAR_CR: begin
				c = BC_BREAK;
			end
			CHAR_TAB, CHAR_VT, CHAR_FF, CHAR_SP: begin
				c = BC_BLANK;
			end
			default: begin
				c = BC_VISIBLE;
			end
		endcase
		return c;
	endfunction

endpackage

>>> src/twn_front.sv
module twn_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  twn_pkg::item_t             item,
	input  logic                       cfg_we,
	input  logic [twn_pkg::CNT_W-1:0]  cfg_wdata,
	input  logic                       q_full,
	output logic                       push,
	output twn_pkg::cmd_t              cmd
);
	import twn_pkg::*;

	logic [CNT_W-1:0] len_cap_q;
	logic             blank_run_q;
	logic             held_newline_q;
	logic             started_q;
	logic [CNT_W-1:0] emitted_count_q;

	byte_class_t      cls;
	logic             accept;
	logic             is_visible;
	logic             sep_want;
	logic             byte_want;
	logic [7:0]       sep_byte;
	logic [LIM_W-1:0] limit;
	logic [LIM_W-1:0] count_ext;
	logic [LIM_W-1:0] count_after_sep;
	logic             sep_ok;
	logic             byte_ok;

	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;

	assign cls        = classify(item.in_byte);
	assign is_visible = item.has_byte && (cls == BC_VISIBLE);

	// A separator goes out ahead of a visible byte: a held newline wins over a space.
	assign sep_want  = is_visible && (held_newline_q || (blank_run_q && started_q));
	assign sep_byte  = held_newline_q ? CHAR_NL : CHAR_SP;
	assign byte_want = is_visible && (item.in_byte != CHAR_NUL);

	assign limit = ({{(LIM_W-CNT_W){1'b0}}, len_cap_q} > LIM_W'(LENGTH_LIMIT)) ?
		LIM_W'(LENGTH_LIMIT) : {{(LIM_W-CNT_W){1'b0}}, len_cap_q};
	assign count_ext       = {{(LIM_W-CNT_W){1'b0}}, emitted_count_q};
	assign sep_ok          = sep_want && (count_ext < limit);
	assign count_after_sep = count_ext + LIM_W'(sep_ok);
	assign byte_ok         = byte_want && (count_after_sep < limit);

	always_comb begin
		cmd.first_byte  = sep_ok ? sep_byte : item.in_byte;
		cmd.second_byte = item.in_byte;
		cmd.two         = sep_ok && byte_ok;
		cmd.bare        = !sep_ok && !byte_ok;
		cmd.eos         = item.last_byte;
	end

	assign push = accept && (sep_ok || byte_ok || item.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cap_q <= LEN_CAP_RESET;
		end else if (cfg_we) begin
			len_cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_run_q     <= 1'b0;
			held_newline_q  <= 1'b0;
			started_q       <= 1'b0;
			emitted_count_q <= '0;
		end else if (accept) begin
			if (item.last_byte) begin
				blank_run_q     <= 1'b0;
				held_newline_q  <= 1'b0;
				started_q       <= 1'b0;
				emitted_count_q <= '0;
			end else if (item.has_byte) begin
				case (cls)
					BC_BREAK: begin
						if (started_q) begin
							held_newline_q <= 1'b1;
						end
						blank_run_q <= 1'b0;
					end
					BC_BLANK: begin
						blank_run_q <= 1'b1;
					end
					default: begin
						started_q       <= 1'b1;
						held_newline_q  <= 1'b0;
						blank_run_q     <= 1'b0;
						emitted_count_q <= emitted_count_q + CNT_W'(sep_ok) + CNT_W'(byte_ok);
					end
				endcase
			end
		end
	end

endmodule

>>> src/twn_fifo.sv
module twn_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  twn_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output twn_pkg::cmd_t head
);
	import twn_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W+1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule

>>> src/twn_back.sv
module twn_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  twn_pkg::cmd_t    head,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_ready,
	output twn_pkg::result_t result
);
	import twn_pkg::*;

	logic    phase_q;
	logic    res_valid_q;
	result_t res_q;
	logic    load;
	result_t next_res;

	assign load = q_valid && (!res_valid_q || result_ready);
	assign pop  = load && (phase_q || !head.two);

	always_comb begin
		if (phase_q) begin
			next_res.out_byte      = head.second_byte;
			next_res.out_valid     = 1'b1;
			next_res.end_of_string = head.eos;
		end else begin
			next_res.out_byte      = head.bare ? CHAR_NUL : head.first_byte;
			next_res.out_valid     = !head.bare;
			next_res.end_of_string = head.eos && !head.two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q     <= !phase_q && head.two;
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= next_res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_phase_on_pair: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (q_valid && head.two))
		else $error("second half of a pair selected without a paired command");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("queue popped while empty");

	a_bare_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.out_valid) |-> (res_q.end_of_string && res_q.out_byte == CHAR_NUL))
		else $error("bare result without end mark");

endmodule

>>> src/text_whitespace_normalizer_core.sv
// Whitespace normalizer: takes a string one item per transfer and emits the normalized
// bytes, collapsing blank runs to one space and CR/LF to one newline, dropping leading
// and trailing blanks and breaks, and capping each string at the programmed length cap.
// The input side takes one item per cycle as long as the four-entry command queue has
// room. Each item turns into zero, one or two results; the output register hands out
// one result per cycle while the receiver is ready, so an item that releases a held
// newline or a pending space together with its own byte occupies the output for two
// results, and that output register sets the sustained rate, which depends on the text.
// Every string ends with exactly one result flagged end_of_string, a bare marker if
// the last item produced no byte. The length cap register may be written only while
// the block is idle.
module text_whitespace_normalizer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  twn_pkg::item_t             item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output twn_pkg::result_t           result,
	input  logic                       cfg_we,
	input  logic [twn_pkg::CNT_W-1:0]  cfg_wdata
);
	import twn_pkg::*;

	// Commands from the classifier to the emitter.
	logic q_push;
	cmd_t q_push_cmd;
	logic q_full;
	logic q_pop;
	logic q_not_empty;
	cmd_t q_head;

	// The front classifies each byte, tracks collapsing state and the per-string
	// count, and decides which bytes survive the length limit.
	twn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.q_full     (q_full),
		.push       (q_push),
		.cmd        (q_push_cmd)
	);

	// The queue lets the input keep running while the output side is stalled
	// or busy with the second byte of a pair.
	twn_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// The back splits each command into individual result transfers.
	twn_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.head         (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

>>> tb/text_whitespace_normalizer_core_test.sv
module text_whitespace_normalizer_core_test;

	import twn_pkg::*;

	// Cycles to wait after the last expected result before a register write or the end of
	// the run. Items that make no result never enter the four-entry command queue.
	localparam int SETTLE_CYCLES = 16;
	// Length of the long receiver hold-off that fills the block and stalls its input.
	localparam int HOLD_CYCLES = 80;

	// The scoreboard keeps its own copy of the string state and of the length cap. Every
	// accepted input transfer is folded into that state, and the bytes it should produce
	// are queued in order. Each output transfer is compared with the oldest queued entry.
	class normalized_text_board;
		logic [CNT_W-1:0] len_cap;
		bit               blank_run;
		bit               held_newline;
		bit               started;
		logic [CNT_W-1:0] emitted_count;
		result_t          awaited_bytes[$];
		int               errors;

		function new();
			len_cap = LEN_CAP_RESET;
			clear_string();
			errors = 0;
		endfunction

		function void clear_string();
			blank_run = 1'b0;
			held_newline = 1'b0;
			started = 1'b0;
			emitted_count = '0;
		endfunction

		// Queues one output byte unless the string has reached its length cap.
		function int add_byte(logic [7:0] b);
			int unsigned cap;
			result_t r;
			cap = (len_cap > LENGTH_LIMIT) ? LENGTH_LIMIT : int'(len_cap);
			if (emitted_count >= cap) begin
				return 0;
			end
			emitted_count = emitted_count + 1'b1;
			r.out_byte = b;
			r.out_valid = 1'b1;
			r.end_of_string = 1'b0;
			awaited_bytes = {awaited_bytes, r};
			return 1;
		endfunction

		function void absorb_item(item_t it);
			int made;
			result_t r;
			made = 0;
			if (it.has_byte) begin
				if (it.in_byte == CHAR_NL || it.in_byte == CHAR_CR) begin
					// A line break before any visible byte is simply dropped.
					if (started) begin
						held_newline = 1'b1;
					end
					blank_run = 1'b0;
				end else if (it.in_byte == CHAR_TAB || it.in_byte == CHAR_VT ||
						it.in_byte == CHAR_FF || it.in_byte == CHAR_SP) begin
					blank_run = 1'b1;
				end else begin
					// A visible byte, NUL included, releases a held newline or else a
					// pending space; NUL itself never reaches the output.
					if (held_newline) begin
						made += add_byte(CHAR_NL);
					end else if (blank_run && started) begin
						made += add_byte(CHAR_SP);
					end
					if (it.in_byte != CHAR_NUL) begin
						made += add_byte(it.in_byte);
					end
					started = 1'b1;
					held_newline = 1'b0;
					blank_run = 1'b0;
				end
			end
			if (it.last_byte) begin
				if (made == 0) begin
					r.out_byte = '0;
					r.out_valid = 1'b0;
					r.end_of_string = 1'b1;
					awaited_bytes = {awaited_bytes, r};
				end else begin
					awaited_bytes[awaited_bytes.size() - 1].end_of_string = 1'b1;
				end
				clear_string();
			end
		endfunction

		function void compare_output(result_t got);
			result_t want;
			if (awaited_bytes.size() == 0) begin
				$error("unexpected result: out_byte %0h out_valid %0b end_of_string %0b",
					got.out_byte, got.out_valid, got.end_of_string);
				errors++;
				return;
			end
			want = awaited_bytes.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.out_valid !== want.out_valid) begin
				$error("out_valid: expected %0b, got %0b", want.out_valid, got.out_valid);
				errors++;
			end
			if (got.end_of_string !== want.end_of_string) begin
				$error("end_of_string: expected %0b, got %0b",
					want.end_of_string, got.end_of_string);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	item_t            item;
	logic             result_valid;
	logic             result_ready;
	result_t          result;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	normalized_text_board board;

	// When steady is set, neither side inserts random idle cycles. Each increment of
	// hold_requests asks the receiver for one long hold-off.
	bit steady;
	int hold_requests;

	text_whitespace_normalizer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// A generous fixed ceiling on the run; a correct run ends far sooner.
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	function automatic item_t make_item(logic [7:0] b, logic has, logic last);
		item_t it;
		it.in_byte = b;
		it.has_byte = has;
		it.last_byte = last;
		return it;
	endfunction

	// Random text weighted toward whitespace, line breaks and NUL, so that collapsing,
	// held newlines and releases happen often. Items without a byte keep random junk.
	function automatic item_t random_item(bit is_last);
		item_t it;
		int pick;
		pick = $urandom_range(99);
		it.in_byte = 8'($urandom_range(255));
		it.has_byte = 1'b1;
		it.last_byte = is_last;
		if (pick < 20) begin
			case ($urandom_range(3))
				0: begin
					it.in_byte = CHAR_TAB;
				end
				1: begin
					it.in_byte = CHAR_VT;
				end
				2: begin
					it.in_byte = CHAR_FF;
				end
				default: begin
					it.in_byte = CHAR_SP;
				end
			endcase
		end else if (pick < 32) begin
			it.in_byte = $urandom_range(1) ? CHAR_NL : CHAR_CR;
		end else if (pick < 36) begin
			it.in_byte = CHAR_NUL;
		end else if (pick < 40) begin
			it.has_byte = 1'b0;
		end
		return it;
	endfunction

	// Offers one item and returns in the time step of its transfer. Random idle cycles
	// come before the offer; once valid is up it stays up with the same payload.
	task automatic send_item(item_t x);
		if (!steady) begin
			while ($urandom_range(99) < 27) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		item <= x;
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		board.absorb_item(x);
	endtask

	task automatic stop_input();
		item_valid <= 1'b0;
	endtask

	// Waits until every expected result has arrived, then lets the block settle.
	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (board.awaited_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_len_cap(logic [CNT_W-1:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.len_cap = v;
	endtask

	// Sends whole strings until about the given number of meaningful items has been
	// transferred. Most strings are short; about one in ten is long enough to hit
	// small length caps many times over.
	task automatic run_strings(int target);
		int sent;
		int len;
		item_t it;
		sent = 0;
		while (sent < target) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				it = random_item(i == len - 1);
				send_item(it);
				if (it.has_byte || it.last_byte) begin
					sent++;
				end
			end
		end
		stop_input();
	endtask

	// The receiver samples the output at each rising edge, checks a transfer when one
	// happens, and then chooses ready for the next cycle. A pending hold-off request
	// takes priority over the random stalls.
	initial begin
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				board.compare_output(result);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES;
				result_ready <= 1'b0;
			end else begin
				result_ready <= steady || ($urandom_range(99) >= 27);
			end
		end
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		steady = 1'b0;
		hold_requests = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed strings under the reset length cap. The first has leading blanks,
		// every blank kind, a CR LF pair, a space after a newline and a trailing
		// newline, so its last transfer yields only the bare end marker.
		send_item(make_item(CHAR_SP, 1'b1, 1'b0));
		send_item(make_item(CHAR_TAB, 1'b1, 1'b0));
		send_item(make_item(8'h41, 1'b1, 1'b0));
		send_item(make_item(CHAR_TAB, 1'b1, 1'b0));
		send_item(make_item(CHAR_VT, 1'b1, 1'b0));
		send_item(make_item(8'h62, 1'b1, 1'b0));
		send_item(make_item(CHAR_FF, 1'b1, 1'b0));
		send_item(make_item(CHAR_CR, 1'b1, 1'b0));
		send_item(make_item(CHAR_NL, 1'b1, 1'b0));
		send_item(make_item(CHAR_SP, 1'b1, 1'b0));
		send_item(make_item(8'h63, 1'b1, 1'b0));
		send_item(make_item(CHAR_NL, 1'b1, 1'b1));
		// An empty string: one end-only item whose byte must be ignored.
		send_item(make_item(8'hA5, 1'b0, 1'b1));
		// NUL releases a pending space and a held newline without being emitted, and
		// an item without a byte in the middle changes nothing.
		send_item(make_item(8'h78, 1'b1, 1'b0));
		send_item(make_item(CHAR_SP, 1'b1, 1'b0));
		send_item(make_item(CHAR_NUL, 1'b1, 1'b0));
		send_item(make_item(CHAR_NL, 1'b1, 1'b0));
		send_item(make_item(8'h5A, 1'b0, 1'b0));
		send_item(make_item(CHAR_NUL, 1'b1, 1'b0));
		send_item(make_item(8'hFF, 1'b1, 1'b1));
		// A leading NUL starts the string, so the following blank run becomes a space,
		// and the last item yields two results, the second carrying the end mark.
		send_item(make_item(CHAR_NUL, 1'b1, 1'b0));
		send_item(make_item(CHAR_SP, 1'b1, 1'b0));
		send_item(make_item(8'h80, 1'b1, 1'b1));
		// A line break and a blank before anything visible give only the end marker.
		send_item(make_item(CHAR_CR, 1'b1, 1'b0));
		send_item(make_item(CHAR_SP, 1'b1, 1'b1));
		stop_input();

		// A zero cap: every string reduces to its end marker.
		write_len_cap(10'd0);
		run_strings(80);

		// The largest cap, reached by one long run of visible bytes; the final byte is
		// dropped, so that string ends with a bare marker.
		write_len_cap(10'd1023);
		for (int i = 0; i < 1040; i++) begin
			send_item(make_item(8'($urandom_range(33, 255)), 1'b1, i == 1039));
		end
		run_strings(100);

		// A small cap with no random idling, and one long receiver hold-off while the
		// sender keeps offering items.
		write_len_cap(10'd3);
		steady = 1'b1;
		hold_requests++;
		run_strings(150);
		steady = 1'b0;

		write_len_cap(10'd1);
		run_strings(80);

		repeat (4) begin
			write_len_cap(CNT_W'($urandom_range(0, 40)));
			run_strings(50);
		end

		write_len_cap(LEN_CAP_RESET);
		hold_requests++;
		run_strings(100);

		wait_drained();
		if (board.awaited_bytes.size() != 0) begin
			$error("%0d expected results never arrived", board.awaited_bytes.size());
			board.errors++;
		end
		if (board.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
